[rtl/core/assert_macros.svh]
// assertion macros shared by the list engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, quiet while reset is high
`define SLE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked property, also during reset
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/sle_pkg.sv]
// shared types and constants of the list engine
package sle_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int GRP_SIZE   = 8;
   localparam int GRP_N      = CAPACITY / GRP_SIZE;
   localparam int SUB_W      = $clog2(GRP_SIZE);
   localparam int GRP_W      = $clog2(GRP_N);

   // operation codes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_GET    = 3'd2;
   localparam logic [2:0] OP_SET    = 3'd3;
   localparam logic [2:0] OP_LOCATE = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NOTFND  = 2'd3;

   typedef struct packed {
      logic [2:0]            operation;
      logic [IDX_W-1:0]      index;
      logic [DATA_WIDTH-1:0] value;
   } sle_req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [DATA_WIDTH-1:0] read_value;
      logic [IDX_W-1:0]      found_index;
      logic [CNT_W-1:0]      list_length;
      logic                  empty_res;
   } sle_rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                  ins;
      logic                  del;
      logic                  set;
      logic [IDX_W-1:0]      idx;
      logic [CNT_W-1:0]      count;
      logic [DATA_WIDTH-1:0] data;
   } sle_bcast_type;

   // per-group search result
   typedef struct packed {
      logic                  hit;
      logic [SUB_W-1:0]      sub;
      logic [DATA_WIDTH-1:0] word;
   } sle_grp_type;

endpackage

[rtl/core/sle_cell.sv]
// one list slot: holds an entry, shifts with its neighbors, compares
module sle_cell (
   input  logic                          clock,
   input  logic [sle_pkg::IDX_W-1:0]      pos,
   input  sle_pkg::sle_bcast_type         bcast,
   input  logic [sle_pkg::DATA_WIDTH-1:0] left_word,
   input  logic [sle_pkg::DATA_WIDTH-1:0] right_word,
   output logic [sle_pkg::DATA_WIDTH-1:0] word_o,
   output logic                          match_o,
   output logic [sle_pkg::DATA_WIDTH-1:0] pick_o
);
   import sle_pkg::*;

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  match_ff, match_in;
   logic [DATA_WIDTH-1:0] pick_ff, pick_in;
   logic [CNT_W-1:0]      pos_w;

   assign pos_w = {1'b0, pos};

   always_comb begin
      entry_in = entry_ff;
      if (bcast.ins) begin
         if (pos == bcast.idx) begin
            entry_in = bcast.data;
         end else if (pos > bcast.idx && pos_w <= bcast.count) begin
            entry_in = left_word;
         end
      end else if (bcast.del) begin
         if (pos >= bcast.idx && (pos_w + CNT_W'(1)) < bcast.count) begin
            entry_in = right_word;
         end
      end else if (bcast.set) begin
         if (pos == bcast.idx) begin
            entry_in = bcast.data;
         end
      end
   end

   // compare and read taken from the word before this cycle's update
   assign match_in = (entry_ff == bcast.data) && (pos_w < bcast.count);
   assign pick_in  = (pos == bcast.idx) ? entry_ff : '0;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
      pick_ff  <= pick_in;
   end

   assign word_o  = entry_ff;
   assign match_o = match_ff;
   assign pick_o  = pick_ff;

endmodule

[rtl/core/sle_group.sv]
// first-match and read merge over one group of cells
module sle_group (
   input  logic                          clock,
   input  logic [sle_pkg::GRP_SIZE-1:0]   match,
   input  logic [sle_pkg::DATA_WIDTH-1:0] pick [sle_pkg::GRP_SIZE],
   output sle_pkg::sle_grp_type           grp_o
);
   import sle_pkg::*;

   sle_grp_type grp_ff, grp_in;

   always_comb begin
      grp_in      = '0;
      grp_in.hit  = |match;
      for (int k = GRP_SIZE - 1; k >= 0; k--) begin
         if (match[k]) begin
            grp_in.sub = SUB_W'(k);
         end
      end
      for (int k = 0; k < GRP_SIZE; k++) begin
         grp_in.word = grp_in.word | pick[k];
      end
   end

   always_ff @(posedge clock) begin
      grp_ff <= grp_in;
   end

   assign grp_o = grp_ff;

endmodule

[rtl/core/sequential_list_engine.sv]
// top level of the list engine: control, length, cell row and result merge
//
// after the accepting edge, in order, the whole row of cells shifts, writes and
// compares at once, each group of eight cells is merged, and the groups are
// merged into the result register; then the result strobe comes up. busy stays
// high from acceptance until the result is registered, so a new transaction can
// be taken at the edge that ends the cycle the previous result is shown. the
// result on rsp_payload is flagged by rsp_strobe for exactly one cycle; there is
// no back pressure, the receiver must take it then. entry words have no reset; a
// get of a slot never written returns whatever it holds. capacity_limit is written
// through the csr channel while idle and is clamped into one to the list capacity.
module sequential_list_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  sle_pkg::sle_req_type      req_payload,
   output logic                      rsp_strobe,
   output sle_pkg::sle_rsp_type      rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [sle_pkg::CNT_W-1:0] csr_wdata
);
   import sle_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [1:0] {S_IDLE, S_EXEC, S_GATHER, S_FINISH} state_type;

   state_type             state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      cap_ff, cap_in;
   logic [1:0]            status_ff, status_in;
   logic                  rd_en_ff, rd_en_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   sle_rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]      lim;
   logic [CNT_W-1:0]      idx_w;
   logic                  exec;
   logic                  op_ok;
   logic [1:0]            exec_status;
   sle_bcast_type         bcast;

   logic [DATA_WIDTH-1:0] cell_word  [CAPACITY];
   logic [DATA_WIDTH-1:0] cell_pick  [CAPACITY];
   logic [CAPACITY-1:0]   cell_match;
   sle_grp_type           grp        [GRP_N];

   logic                  any_hit;
   logic [GRP_W-1:0]      hit_grp;
   logic [SUB_W-1:0]      hit_sub;
   logic [DATA_WIDTH-1:0] merged_word;

   // effective limit, clamped into one to capacity
   always_comb begin
      if (cap_ff == '0) begin
         lim = CNT_W'(1);
      end else if (cap_ff > CNT_W'(CAPACITY)) begin
         lim = CNT_W'(CAPACITY);
      end else begin
         lim = cap_ff;
      end
   end

   assign idx_w = {1'b0, idx_ff};
   assign exec  = (state_ff == S_EXEC);

   // status decision, made in the row update cycle
   always_comb begin
      exec_status = ST_OK;
      case (op_ff)
         OP_INSERT: begin
            if (count_ff >= lim) begin
               exec_status = ST_FULL;
            end else if (idx_w >= lim) begin
               exec_status = ST_RANGE;
            end
         end
         OP_DELETE: begin
            if (idx_w >= lim) begin
               exec_status = ST_RANGE;
            end else if (idx_w >= count_ff) begin
               exec_status = ST_NOTFND;
            end
         end
         OP_GET, OP_SET: begin
            if (idx_w >= lim) begin
               exec_status = ST_RANGE;
            end
         end
         OP_LOCATE: exec_status = ST_OK;
         default:   exec_status = ST_RANGE;
      endcase
   end

   assign op_ok = (exec_status == ST_OK);

   // command to the row; an insert past the end lands at the end
   always_comb begin
      bcast       = '0;
      bcast.ins   = exec && op_ok && (op_ff == OP_INSERT);
      bcast.del   = exec && op_ok && (op_ff == OP_DELETE);
      bcast.set   = exec && op_ok && (op_ff == OP_SET);
      bcast.idx   = (op_ff == OP_INSERT && idx_w > count_ff) ?
                    count_ff[IDX_W-1:0] : idx_ff;
      bcast.count = count_ff;
      bcast.data  = val_ff;
   end

   // row of cells, each shifting to and from its neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_word;
      logic [DATA_WIDTH-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_l
         assign left_word = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_r
         assign right_word = cell_word[i+1];
      end
      sle_cell u_cell (
         .clock      (clock),
         .pos        (IDX_W'(i)),
         .bcast      (bcast),
         .left_word  (left_word),
         .right_word (right_word),
         .word_o     (cell_word[i]),
         .match_o    (cell_match[i]),
         .pick_o     (cell_pick[i])
      );
   end

   // first level of the search and read tree
   for (genvar g = 0; g < GRP_N; g++) begin : g_grp
      logic [DATA_WIDTH-1:0] pick [GRP_SIZE];
      for (genvar k = 0; k < GRP_SIZE; k++) begin : g_pick
         assign pick[k] = cell_pick[g*GRP_SIZE + k];
      end
      sle_group u_group (
         .clock (clock),
         .match (cell_match[g*GRP_SIZE +: GRP_SIZE]),
         .pick  (pick),
         .grp_o (grp[g])
      );
   end

   // second level: lowest group with a hit wins
   always_comb begin
      any_hit     = 1'b0;
      hit_grp     = '0;
      hit_sub     = '0;
      merged_word = '0;
      for (int g = GRP_N - 1; g >= 0; g--) begin
         if (grp[g].hit) begin
            any_hit = 1'b1;
            hit_grp = GRP_W'(g);
            hit_sub = grp[g].sub;
         end
      end
      for (int g = 0; g < GRP_N; g++) begin
         merged_word = merged_word | grp[g].word;
      end
   end

   // sequencer and registers
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      status_in     = status_ff;
      rd_en_in      = rd_en_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_valid && csr_ready) begin
         cap_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_payload.operation;
               idx_in   = req_payload.index;
               val_in   = req_payload.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = exec_status;
            rd_en_in  = op_ok && (op_ff == OP_GET || op_ff == OP_DELETE);
            if (op_ok && op_ff == OP_INSERT) begin
               count_in = count_ff + CNT_W'(1);
            end else if (op_ok && op_ff == OP_DELETE) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = S_GATHER;
         end
         S_GATHER: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            rsp_in.status      = status_ff;
            rsp_in.read_value  = rd_en_ff ? merged_word : '0;
            rsp_in.found_index = '0;
            if (op_ff == OP_LOCATE) begin
               if (any_hit) begin
                  rsp_in.status      = ST_OK;
                  rsp_in.found_index = {hit_grp, hit_sub};
               end else begin
                  rsp_in.status = ST_NOTFND;
               end
            end
            rsp_in.list_length = count_ff;
            rsp_in.empty_res   = (count_ff == '0);
            rsp_strobe_in      = 1'b1;
            state_in           = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         cap_ff        <= CNT_W'(CAPACITY);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff     <= op_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rd_en_ff  <= rd_en_in;
      rsp_ff    <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // every accepted transaction is answered with a result strobe
   `SLE_ASSERT(a_rsp_latency, (start && !busy) |-> ##4 rsp_strobe_ff, "result strobe missing")
   // reported length matches the length register while it is shown
   `SLE_ASSERT(a_rsp_length, rsp_strobe_ff |-> (rsp_ff.list_length == count_ff), "length mismatch")
   // length never runs past the row of cells
   `SLE_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "length beyond capacity")
   // reset leaves the engine idle with no result pending
   `SLE_ASSERT_ALWAYS(a_reset_idle, reset |=> (!rsp_strobe_ff && state_ff == S_IDLE), "reset not idle")

endmodule

[verif/sequential_list_engine_test.sv]
// testbench for the list engine: directed and random list operations checked by a local list model
module sequential_list_engine_test;
   import sle_pkg::*;

   // run guard, far above the slowest legal run
   localparam int CYCLE_LIMIT  = 200000;
   // settle time after the last result
   localparam int SETTLE_CYCLES = 8;
   // operation codes the block does not implement
   localparam logic [2:0] OP_RESERVED_LO = 3'd5;
   localparam logic [2:0] OP_RESERVED_HI = 3'd7;

   // traffic mix of one random phase
   typedef enum {FILL_UP, CHURN, DRAIN_DOWN} traffic_kind_type;

   localparam int PHASES = 9;

   logic             clock;
   logic             reset       = 1'b1;
   logic             start       = 1'b0;
   logic             busy;
   sle_req_type      req_payload = '0;
   logic             rsp_strobe;
   sle_rsp_type      rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_wdata   = '0;

   sequential_list_engine dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   // local copy of the list state, updated at each accepted transaction
   logic [DATA_WIDTH-1:0] list_words [CAPACITY];
   logic [CAPACITY-1:0]   slot_written = '0;
   int unsigned           list_count   = 0;
   logic [CNT_W-1:0]      limit_setting = CNT_W'(CAPACITY);

   sle_req_type pending_ops [$];
   sle_rsp_type expected_rsps [$];

   int unsigned      error_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      idle_left   = 0;
   logic             idle_quiet  = 1'b0;
   logic             config_pending = 1'b0;
   logic [CNT_W-1:0] config_word = '0;

   // driver scratch
   logic        req_taken;
   logic        csr_taken;
   logic        start_next;
   sle_rsp_type predicted;
   sle_rsp_type oldest;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // register value clamped into one to the list capacity
   function automatic int unsigned active_limit();
      if (limit_setting == 0) return 1;
      if (limit_setting > CAPACITY) return CAPACITY;
      return limit_setting;
   endfunction

   // applies one operation to the local list and builds the result it must give
   task automatic run_list_op(input sle_req_type op, output sle_rsp_type res);
      int unsigned lim;
      int unsigned pos;
      int unsigned y;
      lim = active_limit();
      pos = op.index;
      res = '0;
      case (op.operation)
         OP_INSERT: begin
            // a full list is refused before the position is looked at
            if (list_count >= lim) begin
               res.status = ST_FULL;
            end else if (pos >= lim) begin
               res.status = ST_RANGE;
            end else begin
               // a position past the end appends
               if (pos > list_count) pos = list_count;
               for (y = list_count; y > pos; y--) list_words[y] = list_words[y-1];
               list_words[pos] = op.value;
               list_count++;
               for (y = 0; y < list_count; y++) slot_written[y] = 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos >= lim) begin
               res.status = ST_RANGE;
            end else if (pos >= list_count) begin
               res.status = ST_NOTFND;
            end else begin
               // the slot just past the new end keeps its old word
               res.read_value = list_words[pos];
               for (y = pos; y + 1 < list_count; y++) list_words[y] = list_words[y+1];
               list_count--;
            end
         end
         OP_GET: begin
            // checked against the limit only, not the length
            if (pos >= lim) res.status = ST_RANGE;
            else res.read_value = list_words[pos];
         end
         OP_SET: begin
            if (pos >= lim) begin
               res.status = ST_RANGE;
            end else begin
               list_words[pos] = op.value;
               slot_written[pos] = 1'b1;
            end
         end
         OP_LOCATE: begin
            // scan downward so the lowest match is the one that sticks
            res.status = ST_NOTFND;
            for (y = list_count; y > 0; y--) begin
               if (list_words[y-1] == op.value) begin
                  res.status = ST_OK;
                  res.found_index = IDX_W'(y - 1);
               end
            end
         end
         default: res.status = ST_RANGE;
      endcase
      res.list_length = CNT_W'(list_count);
      res.empty_res = (list_count == 0);
   endtask

   // sender gap after a transaction: mostly none or short, now and then long
   function automatic int unsigned pick_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (idle_quiet || r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         idle_left = 0;
      end else begin
         // configuration channel, only used while the engine is idle
         csr_taken = csr_valid && csr_ready;
         if (csr_taken) begin
            limit_setting = csr_wdata;
            config_pending = 1'b0;
            csr_valid <= 1'b0;
         end else if (config_pending && !csr_valid) begin
            csr_valid <= 1'b1;
            csr_wdata <= config_word;
         end

         // command channel: predict the result at the accepting edge
         req_taken = start && !busy;
         if (req_taken) begin
            run_list_op(req_payload, predicted);
            expected_rsps.push_back(predicted);
            void'(pending_ops.pop_front());
            idle_left = pick_idle();
         end

         // start is assigned once per edge: held while busy, else next item or gap
         if (start && !req_taken) begin
            start_next = 1'b1;
         end else if (idle_left != 0) begin
            idle_left--;
            start_next = 1'b0;
         end else if (pending_ops.size() != 0 && !config_pending) begin
            start_next = 1'b1;
            req_payload <= pending_ops[0];
         end else begin
            start_next = 1'b0;
         end
         start <= start_next;
      end
   end

   function automatic void compare_field(string field_name, logic [63:0] want,
                                         logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, field_name, want, got);
         error_count++;
      end
   endfunction

   // results cannot be held off, so every strobe is taken as it comes
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result with none outstanding, expected nothing, actual %p",
                     $time, rsp_payload);
            error_count++;
         end else begin
            oldest = expected_rsps.pop_front();
            compare_field("status", oldest.status, rsp_payload.status);
            compare_field("read_value", oldest.read_value, rsp_payload.read_value);
            compare_field("found_index", oldest.found_index, rsp_payload.found_index);
            compare_field("list_length", oldest.list_length, rsp_payload.list_length);
            compare_field("empty_res", oldest.empty_res, rsp_payload.empty_res);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // the generator works on falling edges, so it never races the driver;
   // one command is queued at a time, so the list model is current when
   // the next one is chosen
   task automatic queue_op(input logic [2:0] op, input int unsigned pos,
                           input logic [DATA_WIDTH-1:0] word);
      sle_req_type item;
      int unsigned reach;
      while (pending_ops.size() != 0) @(negedge clock);
      // never read a slot that was never written
      if (op == OP_GET && pos < active_limit() && !slot_written[pos]) begin
         reach = (list_count < active_limit()) ? list_count : active_limit();
         if (reach != 0) pos = $urandom_range(0, reach - 1);
         else op = OP_SET;
      end
      item.operation = op;
      item.index = IDX_W'(pos);
      item.value = word;
      pending_ops.push_back(item);
   endtask

   // wait until the engine is idle with nothing outstanding
   task automatic settle();
      while (pending_ops.size() != 0 || expected_rsps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(input logic [CNT_W-1:0] setting);
      settle();
      config_word = setting;
      config_pending = 1'b1;
      while (config_pending) @(negedge clock);
   endtask

   task automatic random_op(input traffic_kind_type kind);
      logic [2:0]            op;
      int unsigned           pos;
      logic [DATA_WIDTH-1:0] word;
      int unsigned           r;
      int unsigned           ins_cut;
      int unsigned           del_cut;
      r = $urandom_range(0, 99);
      case (kind)
         FILL_UP:    begin ins_cut = 85; del_cut = 88; end
         DRAIN_DOWN: begin ins_cut = 12; del_cut = 70; end
         default:    begin ins_cut = 30; del_cut = 50; end
      endcase
      if (r < ins_cut) op = OP_INSERT;
      else if (r < del_cut) op = OP_DELETE;
      else if (r < del_cut + (100 - del_cut) * 4 / 10) op = OP_GET;
      else if (r < del_cut + (100 - del_cut) * 6 / 10) op = OP_SET;
      else if (r < 97) op = OP_LOCATE;
      else op = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));

      // positions cluster around the filled part, with the extremes mixed in
      r = $urandom_range(0, 9);
      if (r < 5) pos = $urandom_range(0, (list_count < CAPACITY) ? list_count : CAPACITY - 1);
      else if (r < 8) pos = $urandom_range(0, CAPACITY - 1);
      else if (r == 8) pos = CAPACITY - 1;
      else pos = 0;

      // values often repeat list contents so locate hits and duplicates occur
      r = $urandom_range(0, 9);
      if (r < 4 || (r < 8 && list_count == 0)) word = $urandom;
      else if (r < 8) word = list_words[$urandom_range(0, list_count - 1)];
      else if (r == 8) word = '0;
      else word = '1;
      queue_op(op, pos, word);
   endtask

   initial begin
      int unsigned      limit_plan [PHASES] = '{127, 3, 64, 0, 8, 1, 64, 100, 2};
      traffic_kind_type kind_plan [PHASES] = '{FILL_UP, CHURN, DRAIN_DOWN, CHURN, FILL_UP,
                                               CHURN, CHURN, FILL_UP, DRAIN_DOWN};
      int unsigned      size_plan [PHASES] = '{100, 40, 90, 60, 80, 60, 120, 90, 60};
      logic [2:0]       odd_op;
      int unsigned      setting;
      int unsigned      n;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list, limit at its reset value of the full capacity
      queue_op(OP_DELETE, 0, '0);                  // nothing to remove
      queue_op(OP_LOCATE, 0, '0);                  // nothing to search
      queue_op(OP_INSERT, 0, '0);
      queue_op(OP_INSERT, CAPACITY - 1, '1);       // far position appends
      queue_op(OP_INSERT, 1, 32'hA5A5_5A5A);       // middle insert shifts up
      queue_op(OP_INSERT, 0, '1);                  // duplicate at the head
      queue_op(OP_GET, 2, '0);
      queue_op(OP_LOCATE, 0, '1);                  // first of two matches
      queue_op(OP_LOCATE, 0, 32'h1234_5678);       // no match
      queue_op(OP_SET, CAPACITY - 1, 32'h5555_AAAA); // past the length, inside limit
      queue_op(OP_GET, CAPACITY - 1, '0);
      queue_op(OP_LOCATE, 0, 32'h5555_AAAA);       // beyond the length, not searched
      queue_op(OP_DELETE, CAPACITY - 1, '0);       // inside limit, past the length
      queue_op(OP_DELETE, 1, '0);                  // middle delete shifts down
      queue_op(OP_GET, 3, '0);                     // vacated slot keeps its word
      for (odd_op = OP_RESERVED_LO; odd_op <= OP_RESERVED_HI && odd_op >= OP_RESERVED_LO;
           odd_op++) begin
         queue_op(odd_op, 0, '1);                  // undefined operation codes
      end

      // zero clamps to a one slot limit, below the current length
      write_limit('0);
      queue_op(OP_INSERT, 0, 32'h0BAD_F00D);       // refused as full
      queue_op(OP_GET, 1, '0);
      queue_op(OP_SET, 1, '1);
      queue_op(OP_DELETE, 1, '0);
      queue_op(OP_DELETE, 0, '0);

      // small limit: fill it, then refuse
      write_limit(CNT_W'(4));
      queue_op(OP_INSERT, 3, 32'h0000_0001);
      queue_op(OP_INSERT, 0, 32'h8000_0000);
      queue_op(OP_INSERT, 2, 32'h7FFF_FFFF);       // refused as full
      queue_op(OP_INSERT, CAPACITY - 1, '0);

      // random phases, each started from an idle engine with a new limit
      for (int p = 0; p < PHASES; p++) begin
         setting = (p == 6) ? $urandom_range(1, 126) : limit_plan[p];
         write_limit(CNT_W'(setting));
         idle_quiet = (p % 3 == 2);
         for (n = 0; n < size_plan[p]; n++) random_op(kind_plan[p]);
      end
      idle_quiet = 1'b0;

      settle();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sequential_list_engine.f]
+incdir+rtl/core
rtl/core/sle_pkg.sv
rtl/core/sle_cell.sv
rtl/core/sle_group.sv
rtl/core/sequential_list_engine.sv
verif/sequential_list_engine_test.sv
